// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg - shared types and constants of the bisulfite pileup accumulator
// Row layout of the pileup memory, job format between front and back end,
// register indexes and the strand/base category table.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int CATEGORIES   = 8;
  localparam int OFF_W        = $clog2(WINDOW_DEPTH);
  localparam int CAT_W        = $clog2(CATEGORIES);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;

  localparam logic [15:0] CNT_MAX  = 16'hFFFF;
  localparam logic [21:0] QSUM_MAX = 22'h3FFFFF;
  localparam logic [31:0] MSQ_MAX  = 32'hFFFFFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_QUAL_FLOOR = 2'd0;
  localparam logic [1:0] REG_FILT_QUAL  = 2'd1;
  localparam logic [1:0] REG_WIN_START  = 2'd2;
  localparam logic [1:0] REG_WIN_LEN    = 2'd3;

  localparam logic [1:0] STRAND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [OFF_W-1:0] offset;
    logic [CAT_W-1:0] cat;
    logic             ori;
    logic [5:0]       qual;
    logic [15:0]      sq;
  } job_t;

  typedef struct packed {
    logic [15:0] cnt_fwd;
    logic [15:0] cnt_rev;
    logic [21:0] qsum;
  } cat_acc_t;

  typedef struct packed {
    logic [15:0]                      depth;
    logic [31:0]                      msq;
    cat_acc_t [CATEGORIES-1:0]        cat;
  } row_t;

  // Category of a base on a conversion strand, zero based
  function automatic logic [CAT_W-1:0] cat_lookup(input logic [1:0] strand,
                                                   input logic [1:0] base);
    logic [CAT_W-1:0] c;
    c = '0;
    case (strand)
      2'd0: begin
        case (base)
          2'd0: c = 3'd0;
          2'd1: c = 3'd1;
          2'd2: c = 3'd2;
          default: c = 3'd3;
        endcase
      end
      2'd1: begin
        case (base)
          2'd0: c = 3'd0;
          2'd1: c = 3'd5;
          2'd2: c = 3'd2;
          default: c = 3'd7;
        endcase
      end
      2'd2: begin
        case (base)
          2'd0: c = 3'd4;
          2'd1: c = 3'd1;
          2'd2: c = 3'd6;
          default: c = 3'd3;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/bpa_front.sv =====
// ----------------------------------------------------------------------------
// bpa_front - input classifier
// Holds the configuration registers, applies the window and quality tests,
// looks up the category, squares mapq and pushes one job per kept item.
// ----------------------------------------------------------------------------
module bpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bpa_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          q_push,
  output bpa_pkg::job_t                 q_job
);
  import bpa_pkg::*;

  logic [5:0]  qual_floor_r;
  logic [5:0]  filt_qual_r;
  logic [31:0] win_start_r;
  logic [12:0] win_len_r;

  logic [31:0] position;
  logic [1:0]  base;
  logic [5:0]  qual;
  logic [1:0]  strand;
  logic        ori;
  logic [7:0]  mapq;
  logic [31:0] off;
  logic [31:0] len_eff;
  logic        in_win;
  logic        keep;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_floor_r <= 6'd1;
      filt_qual_r  <= 6'd63;
      win_start_r  <= '0;
      win_len_r    <= 13'(WINDOW_DEPTH);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_QUAL_FLOOR: qual_floor_r <= cfg_wdata[5:0];
        REG_FILT_QUAL:  filt_qual_r  <= cfg_wdata[5:0];
        REG_WIN_START:  win_start_r  <= cfg_wdata;
        REG_WIN_LEN:    win_len_r    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign position = in_tdata[31:0];
  assign base     = in_tdata[33:32];
  assign qual     = in_tdata[39:34];
  assign strand   = in_tdata[41:40];
  assign ori      = in_tdata[42];
  assign mapq     = in_tdata[50:43];

  always_comb begin
    off     = position - win_start_r;
    len_eff = ({19'd0, win_len_r} > 32'(WINDOW_DEPTH)) ? 32'(WINDOW_DEPTH)
                                                       : {19'd0, win_len_r};
    in_win  = off < len_eff;
  end

  always_comb begin
    q_job        = '0;
    q_job.offset = off[OFF_W-1:0];
    q_job.cat    = cat_lookup(strand, base);
    q_job.ori    = ori;
    q_job.qual   = qual;
    q_job.sq     = {8'd0, mapq} * {8'd0, mapq};
    keep         = 1'b0;
    if (in_tuser) begin
      keep     = 1'b1;
      q_job.op = in_win ? OP_READ : OP_READ_ZERO;
    end else begin
      q_job.op = OP_UPDATE;
      keep     = in_win && (strand != STRAND_UNUSED) && (qual >= qual_floor_r)
                 && (qual != filt_qual_r);
    end
  end

  assign in_tready = !q_full && !clearing;
  assign accept    = in_tvalid && in_tready;
  // drop out-of-window and rejected bases here
  assign q_push    = accept && keep;

endmodule

// ===== hdl/bpa_queue.sv =====
// ----------------------------------------------------------------------------
// bpa_queue - job queue between front and back end
// Small register FIFO so the classifier and the memory engine stall apart.
// ----------------------------------------------------------------------------
module bpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpa_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output bpa_pkg::job_t head
);
  import bpa_pkg::*;

  job_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic [Q_AW:0]   cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/bpa_back.sv =====
// ----------------------------------------------------------------------------
// bpa_back - pileup memory engine
// One row per window position holds depth, mapq-squared sum and the eight
// category accumulators. Bases do a read-modify-write of their row; a readout
// in the window reads the row, writes it back as zero and emits eight results.
// ----------------------------------------------------------------------------
module bpa_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  bpa_pkg::job_t                  q_head,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [bpa_pkg::CAT_W-1:0]      out_tuser,
  output logic                           out_tlast
);
  import bpa_pkg::*;

  row_t             mem [WINDOW_DEPTH];
  row_t             rd_data_r;
  state_t           state_r, state_nxt;
  job_t             job_r;
  logic             zero_r;
  logic [CAT_W-1:0] k_r;
  logic [OFF_W-1:0] clr_cnt_r;

  logic             rd_en;
  logic             wr_en;
  logic [OFF_W-1:0] wr_addr;
  row_t             wr_data;
  row_t             upd_row;
  logic             load_out;

  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [CAT_W-1:0] out_cat_r;
  logic             out_last_r;

  cat_acc_t         acc;
  logic [22:0]      qsum_add;
  logic [32:0]      msq_add;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[q_head.offset];
  end

  // Row update for a base
  always_comb begin
    upd_row  = rd_data_r;
    acc      = rd_data_r.cat[job_r.cat];
    qsum_add = {1'b0, acc.qsum} + {17'd0, job_r.qual};
    msq_add  = {1'b0, rd_data_r.msq} + {17'd0, job_r.sq};
    upd_row.depth = (rd_data_r.depth == CNT_MAX) ? CNT_MAX : rd_data_r.depth + 1'b1;
    upd_row.msq   = msq_add[32] ? MSQ_MAX : msq_add[31:0];
    acc.qsum      = (qsum_add > {1'b0, QSUM_MAX}) ? QSUM_MAX : qsum_add[21:0];
    if (job_r.ori) begin
      acc.cnt_rev = (acc.cnt_rev == CNT_MAX) ? CNT_MAX : acc.cnt_rev + 1'b1;
    end else begin
      acc.cnt_fwd = (acc.cnt_fwd == CNT_MAX) ? CNT_MAX : acc.cnt_fwd + 1'b1;
    end
    upd_row.cat[job_r.cat] = acc;
  end

  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == OFF_W'(WINDOW_DEPTH-1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty) state_nxt = (q_head.op == OP_READ_ZERO) ? ST_EMIT : ST_READ;
      end
      ST_READ:  state_nxt = (job_r.op == OP_UPDATE) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (load_out && k_r == CAT_W'(CATEGORIES-1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = job_r.offset;
    wr_data  = '0;
    clearing = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = clr_cnt_r;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
        rd_en = !q_empty;
      end
      ST_READ: begin
        wr_en   = 1'b1;
        // a readout leaves its row cleared
        wr_data = (job_r.op == OP_UPDATE) ? upd_row : '0;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      k_r       <= '0;
      zero_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (q_pop) begin
        k_r    <= '0;
        zero_r <= q_head.op == OP_READ_ZERO;
      end else if (load_out) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cat_r  <= k_r;
      out_last_r <= k_r == CAT_W'(CATEGORIES-1);
      if (zero_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {2'b00, rd_data_r.msq, rd_data_r.depth,
                       rd_data_r.cat[k_r].qsum, rd_data_r.cat[k_r].cnt_rev,
                       rd_data_r.cat[k_r].cnt_fwd};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cat_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/bisulfite_pileup_accumulator.sv =====
// ----------------------------------------------------------------------------
// bisulfite_pileup_accumulator - pileup store over a window of positions
// Base items add to depth, quality, mapq-squared and orientation counts of
// their position; readout items report eight categories and clear it.
// ----------------------------------------------------------------------------
// After reset the block sweeps its pileup memory to zero, one row per cycle;
// in_tready stays low until that pass is done, while configuration writes
// are taken as ever. In the memory engine a base item has a registered row
// read, then a saturating update and write back on the single row memory; a
// readout reads its row, writes it back as zero and emits eight results, an
// out-of-window readout goes straight to its eight results since it has no
// row to clear; results wait while out_tready is held low. Dropped bases are
// taken by the classifier and never reach the memory. A four-entry job queue
// sits between the classifier and the memory engine, and the output register
// lets the next job start while the last result of a readout still waits.
module bisulfite_pileup_accumulator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // position[31:0], base[33:32], qual[39:34], strand[41:40],
  // orientation[42], mapq[50:43], zero fill[55:51]
  input  logic [bpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // count_fwd[15:0], count_rev[31:16], quality_sum[53:32], depth[69:54],
  // mapq_sq_sum[101:70], zero fill[103:102]
  output logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata,
  // category[2:0]
  output logic [bpa_pkg::CAT_W-1:0]      out_tuser,
  output logic                           out_tlast
);
  import bpa_pkg::*;

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_head;
  logic clearing;

  bpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  bpa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  bpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
